// File: design/avr_pkg.sv
`timescale 1ns / 1ps
package avr_pkg;

  localparam int TRIG_STAGES_DEF = 16;
  localparam int TRIG_STAGES_MAX = 24;

  // Q30 angle and CORDIC gain constants, and one in Q24
  localparam logic signed [34:0] PI_Q30      = 35'sd3373259426;
  localparam logic signed [34:0] HALF_PI_Q30 = 35'sd1686629713;
  localparam logic signed [32:0] GAIN_Q30    = 33'sd652032874;
  localparam logic signed [27:0] ONE_Q24     = 28'sd16777216;

  // order of the axis outer products
  localparam int UU_XX = 0;
  localparam int UU_YY = 1;
  localparam int UU_ZZ = 2;
  localparam int UU_XY = 3;
  localparam int UU_XZ = 4;
  localparam int UU_YZ = 5;

  // data that rides alongside the CORDIC
  typedef struct packed {
    logic [2:0][31:0] eye;
    logic [2:0][32:0] d;
    logic [2:0][17:0] u;
    logic [5:0][35:0] uu;
    logic             neg;
  } avr_side_t;

  typedef struct packed {
    logic signed [32:0] x;
    logic signed [32:0] y;
    logic signed [32:0] z;
    avr_side_t          side;
  } avr_rot_t;

  // arctangent of 2^-idx, truncated to Q30
  function automatic logic [31:0] atan_q30(input int unsigned idx);
    logic [31:0] val;
    case (idx)
      0:  val = 32'h3243F6A8;
      1:  val = 32'h1DAC6705;
      2:  val = 32'h0FADBAFC;
      3:  val = 32'h07F56EA6;
      4:  val = 32'h03FEAB76;
      5:  val = 32'h01FFD55B;
      6:  val = 32'h00FFFAAA;
      7:  val = 32'h007FFF55;
      8:  val = 32'h003FFFEA;
      9:  val = 32'h001FFFFD;
      10: val = 32'h000FFFFF;
      11: val = 32'h0007FFFF;
      12: val = 32'h0003FFFF;
      13: val = 32'h0001FFFF;
      14: val = 32'h0000FFFF;
      15: val = 32'h00007FFF;
      16: val = 32'h00003FFF;
      17: val = 32'h00001FFF;
      18: val = 32'h00000FFF;
      19: val = 32'h000007FF;
      20: val = 32'h000003FF;
      21: val = 32'h000001FF;
      22: val = 32'h000000FF;
      23: val = 32'h0000007F;
      default: val = 32'h00000000;
    endcase
    return val;
  endfunction

endpackage

// File: design/avr_cordic.sv
`timescale 1ns / 1ps
module avr_cordic #(
  parameter int N = avr_pkg::TRIG_STAGES_DEF
) (
  input  logic             clk_i,
  input  logic [N-1:0]     en_i,
  input  avr_pkg::avr_rot_t in_i,
  output avr_pkg::avr_rot_t out_o
);
  import avr_pkg::*;

  avr_rot_t st_q [N];

  for (genvar k = 0; k < N; k++) begin : g_stage
    localparam logic signed [32:0] Atan = 33'(atan_q30(k));
    avr_rot_t src;
    avr_rot_t nxt;

    assign src = (k == 0) ? in_i : st_q[(k == 0) ? 0 : k - 1];

    // rotate toward zero residual; zero counts as positive
    always_comb begin
      nxt = src;
      if (!src.z[32]) begin
        nxt.x = src.x - (src.y >>> k);
        nxt.y = src.y + (src.x >>> k);
        nxt.z = src.z - Atan;
      end else begin
        nxt.x = src.x + (src.y >>> k);
        nxt.y = src.y - (src.x >>> k);
        nxt.z = src.z + Atan;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i[k]) begin
        st_q[k] <= nxt;
      end
    end
  end

  assign out_o = st_q[N-1];

endmodule

// File: design/axis_angle_view_rotation_unit.sv
`timescale 1ns / 1ps
// Each transaction passes the entry stage, the CORDIC stages and stages B to G to the result.
// Throughput: one transaction per cycle while the output is not stalled; one CORDIC iteration per stage sets the depth.
// A stalled output holds; empty stages still fill, so input stalls only when all are full.
// Reset (rst_ni low, asynchronous) clears all stage valid bits; data registers keep no reset.
module axis_angle_view_rotation_unit #(
  parameter int TRIG_STAGES = avr_pkg::TRIG_STAGES_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [31:0] eye_x_i,
  input  logic signed [31:0] eye_y_i,
  input  logic signed [31:0] eye_z_i,
  input  logic signed [31:0] aim_x_i,
  input  logic signed [31:0] aim_y_i,
  input  logic signed [31:0] aim_z_i,
  input  logic signed [18:0] turn_angle_i,
  input  logic signed [17:0] axis_x_i,
  input  logic signed [17:0] axis_y_i,
  input  logic signed [17:0] axis_z_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] new_aim_x_o,
  output logic signed [31:0] new_aim_y_o,
  output logic signed [31:0] new_aim_z_o,
  output logic               clipped_o
);
  import avr_pkg::*;

  localparam int N = (TRIG_STAGES > TRIG_STAGES_MAX) ? TRIG_STAGES_MAX :
                     (TRIG_STAGES < 1) ? 1 : TRIG_STAGES;
  localparam int L = N + 7;
  localparam int SB = N + 1;
  localparam int SC = N + 2;
  localparam int SD = N + 3;
  localparam int SE = N + 4;
  localparam int SF = N + 5;
  localparam int SG = N + 6;

  logic [L-1:0] v_q;
  logic [L:0]   en;

  // advance a stage when it is empty or its successor advances
  always_comb begin
    en[L] = !out_stall_i;
    for (int k = L - 1; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  assign in_stall_o = !en[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int k = 0; k < L; k++) begin
        if (en[k]) begin
          v_q[k] <= (k == 0) ? in_valid_i : v_q[(k == 0) ? 0 : k - 1];
        end
      end
    end
  end

  // entry stage: direction, axis products, angle reduction
  avr_rot_t s0_d, s0_q;
  logic signed [34:0] ang;
  logic signed [34:0] zr;
  logic signed [17:0] ux, uy, uz;

  always_comb begin
    ux = axis_x_i;
    uy = axis_y_i;
    uz = axis_z_i;
    ang = 35'(turn_angle_i) <<< 14;
    s0_d.side.neg = 1'b0;
    zr = ang;
    if (ang > HALF_PI_Q30) begin
      zr = ang - PI_Q30;
      s0_d.side.neg = 1'b1;
    end else if (ang < -HALF_PI_Q30) begin
      zr = ang + PI_Q30;
      s0_d.side.neg = 1'b1;
    end
    s0_d.x = GAIN_Q30;
    s0_d.y = '0;
    s0_d.z = zr[32:0];
    s0_d.side.eye[0] = eye_x_i;
    s0_d.side.eye[1] = eye_y_i;
    s0_d.side.eye[2] = eye_z_i;
    s0_d.side.d[0] = 33'(aim_x_i) - 33'(eye_x_i);
    s0_d.side.d[1] = 33'(aim_y_i) - 33'(eye_y_i);
    s0_d.side.d[2] = 33'(aim_z_i) - 33'(eye_z_i);
    s0_d.side.u[0] = ux;
    s0_d.side.u[1] = uy;
    s0_d.side.u[2] = uz;
    s0_d.side.uu[UU_XX] = 36'(ux) * 36'(ux);
    s0_d.side.uu[UU_YY] = 36'(uy) * 36'(uy);
    s0_d.side.uu[UU_ZZ] = 36'(uz) * 36'(uz);
    s0_d.side.uu[UU_XY] = 36'(ux) * 36'(uy);
    s0_d.side.uu[UU_XZ] = 36'(ux) * 36'(uz);
    s0_d.side.uu[UU_YZ] = 36'(uy) * 36'(uz);
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      s0_q <= s0_d;
    end
  end

  // sine and cosine iterations
  avr_rot_t cr;

  avr_cordic #(.N(N)) u_cordic (
    .clk_i (clk_i),
    .en_i  (en[N:1]),
    .in_i  (s0_q),
    .out_o (cr)
  );

  // stage B: fold sign, round to Q24, form t = 1 - c
  logic signed [33:0] xn, yn, xr, yr;
  logic signed [26:0] c_d, s_d, c_b_q, s_b_q;
  logic signed [27:0] t_d, t_b_q;
  avr_side_t side_b_q;

  always_comb begin
    xn = cr.side.neg ? -34'(cr.x) : 34'(cr.x);
    yn = cr.side.neg ? -34'(cr.y) : 34'(cr.y);
    xr = xn + 34'sd32;
    yr = yn + 34'sd32;
    c_d = xr[32:6];
    s_d = yr[32:6];
    t_d = ONE_Q24 - 28'(c_d);
  end

  always_ff @(posedge clk_i) begin
    if (en[SB]) begin
      c_b_q <= c_d;
      s_b_q <= s_d;
      t_b_q <= t_d;
      side_b_q <= cr.side;
    end
  end

  // stage C: matrix products
  logic signed [63:0] pt_c_q [6];
  logic signed [44:0] ps_c_q [3];
  logic signed [26:0] c_c_q;
  avr_side_t side_c_q;

  always_ff @(posedge clk_i) begin
    if (en[SC]) begin
      for (int k = 0; k < 6; k++) begin
        pt_c_q[k] <= 64'(t_b_q) * 64'($signed(side_b_q.uu[k]));
      end
      for (int k = 0; k < 3; k++) begin
        ps_c_q[k] <= 45'(s_b_q) * 45'($signed(side_b_q.u[k]));
      end
      c_c_q <= c_b_q;
      side_c_q <= side_b_q;
    end
  end

  // stage D: round products and assemble the matrix
  logic signed [63:0] ptr [6];
  logic signed [44:0] psr [3];
  logic signed [31:0] mt [6];
  logic signed [31:0] ms [3];
  logic signed [31:0] cc;
  logic signed [31:0] m_d [3][3];
  logic signed [31:0] m_q [3][3];
  avr_side_t side_d_q;

  always_comb begin
    for (int k = 0; k < 6; k++) begin
      ptr[k] = pt_c_q[k] + (64'sd1 <<< 31);
      mt[k] = ptr[k][63:32];
    end
    for (int k = 0; k < 3; k++) begin
      psr[k] = ps_c_q[k] + 45'sd32768;
      ms[k] = 32'($signed(psr[k][44:16]));
    end
    cc = 32'(c_c_q);
    m_d[0][0] = mt[UU_XX] + cc;
    m_d[0][1] = mt[UU_XY] - ms[2];
    m_d[0][2] = mt[UU_XZ] + ms[1];
    m_d[1][0] = mt[UU_XY] + ms[2];
    m_d[1][1] = mt[UU_YY] + cc;
    m_d[1][2] = mt[UU_YZ] - ms[0];
    m_d[2][0] = mt[UU_XZ] - ms[1];
    m_d[2][1] = mt[UU_YZ] + ms[0];
    m_d[2][2] = mt[UU_ZZ] + cc;
  end

  always_ff @(posedge clk_i) begin
    if (en[SD]) begin
      m_q <= m_d;
      side_d_q <= side_c_q;
    end
  end

  // stage E: matrix times direction
  logic signed [63:0] pr_q [3][3];
  logic [2:0][31:0]   eye_e_q;

  always_ff @(posedge clk_i) begin
    if (en[SE]) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          pr_q[i][j] <= 64'(m_q[i][j]) * 64'($signed(side_d_q.d[j]));
        end
      end
      eye_e_q <= side_d_q.eye;
    end
  end

  // stage F: sum each row
  logic signed [63:0] acc_q [3];
  logic [2:0][31:0]   eye_f_q;

  always_ff @(posedge clk_i) begin
    if (en[SF]) begin
      for (int i = 0; i < 3; i++) begin
        acc_q[i] <= pr_q[i][0] + pr_q[i][1] + pr_q[i][2];
      end
      eye_f_q <= eye_e_q;
    end
  end

  // stage G: round to Q16, add eye, saturate
  logic signed [63:0] accr [3];
  logic signed [39:0] rq [3];
  logic signed [41:0] rs [3];
  logic signed [31:0] res_d [3];
  logic signed [31:0] res_q [3];
  logic [2:0]         sat;
  logic               clip_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      accr[i] = acc_q[i] + 64'sd8388608;
      rq[i] = accr[i][63:24];
      rs[i] = 42'(rq[i]) + 42'($signed(eye_f_q[i]));
      sat[i] = 1'b1;
      if (rs[i] > 42'sd2147483647) begin
        res_d[i] = 32'sh7FFFFFFF;
      end else if (rs[i] < -42'sd2147483648) begin
        res_d[i] = 32'sh80000000;
      end else begin
        res_d[i] = rs[i][31:0];
        sat[i] = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[SG]) begin
      res_q <= res_d;
      clip_q <= |sat;
    end
  end

  assign out_valid_o = v_q[L-1];
  assign new_aim_x_o = res_q[0];
  assign new_aim_y_o = res_q[1];
  assign new_aim_z_o = res_q[2];
  assign clipped_o   = clip_q;

  // an empty output stage never blocks input
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled while output stage empty");

  // input stalls only with every stage occupied
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (&v_q))
    else $error("input stalled with a bubble in the pipeline");

  // a clip flag comes with a saturated component
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && clipped_o) |->
      (new_aim_x_o == 32'sh7FFFFFFF || new_aim_x_o == 32'sh80000000 ||
       new_aim_y_o == 32'sh7FFFFFFF || new_aim_y_o == 32'sh80000000 ||
       new_aim_z_o == 32'sh7FFFFFFF || new_aim_z_o == 32'sh80000000))
    else $error("clip flag without saturated component");

endmodule
